>>> hdl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants for the process page slot allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  // Default sizes
  localparam int SLOTS_DEF      = 4;
  localparam int PAGES_DEF      = 1024;

  // Field widths
  localparam int OP_W           = 2;
  localparam int ID_W           = 64;
  localparam int STATUS_W       = 2;
  localparam int SLOT_IDX_W     = 2;
  localparam int VA_W           = 24;

  // Virtual address layout
  localparam int VA_SLOT_SHIFT  = 22;
  localparam int VA_PAGE_SHIFT  = 12;

  // Page bitmap word
  localparam int WORD_W         = 32;
  localparam int BIT_W          = $clog2(WORD_W);

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_KILL   = 2'd1,
    OP_ALLOC  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_NO_SLOT   = 2'd2,
    STS_NO_PAGE   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_SWEEP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_RESP
  } psa_state_e;

  // Controller to datapath
  typedef struct packed {
    logic    capture;      // latch the incoming command
    logic    set_slot;     // latch the looked-up slot
    logic    create_wr;    // write owner id into the empty slot
    logic    owner_clr;    // empty the found slot
    logic    mem_clr;      // reset clearing pass write
    logic    sweep_wr;     // zero one bitmap word of the slot
    logic    word_clr;
    logic    word_inc;
    logic    mem_rd;       // read one bitmap word
    logic    mark_wr;      // set the first free page bit
    logic    res_set;      // load pending result
    status_e res_status;
    logic    res_use_slot;
    logic    res_va;
    logic    out_load;     // move pending result to the output register
  } psa_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            id_zero;
    logic            hit;
    logic            empty_avail;
    logic            clr_last;
    logic            word_last;
    logic            page_free;
    logic            out_busy;
  } psa_sts_t;

endpackage

>>> hdl/process_page_slot_allocator.sv
// ----------------------------------------------------------------------------
// process_page_slot_allocator
// Process slot table with a first-fit page bitmap per slot.
// ----------------------------------------------------------------------------
// Each command (create, kill, allocate) is taken on an in_valid_i/in_ready_o
// transfer and answered by exactly one result transfer on out_valid_o /
// out_ready_i. Commands are handled one at a time; a new command may be taken
// while the previous result is still waiting at the output register. Create
// and failed lookups go from the lookup state straight to the result state.
// A kill that hits then zeroes the slot's WORDS = ceil(PAGES_PER_SLOT/32)
// bitmap words, one 32-bit word per cycle. Allocate reads bitmap words until
// a free page is found (at most WORDS words); each word takes one memory read
// and one check. After reset the bitmap memory is cleared one word per cycle,
// all 2**(SLOT_W + WIDX_W) words (128 with default sizes), before the first
// command is taken.
// ----------------------------------------------------------------------------
module process_page_slot_allocator #(
  parameter int SLOTS          = psa_pkg::SLOTS_DEF,
  parameter int PAGES_PER_SLOT = psa_pkg::PAGES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // command channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [psa_pkg::OP_W-1:0]       operation_i,
  input  logic [psa_pkg::ID_W-1:0]       process_id_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [psa_pkg::STATUS_W-1:0]   status_o,
  output logic [psa_pkg::SLOT_IDX_W-1:0] slot_index_o,
  output logic [psa_pkg::VA_W-1:0]       virtual_address_o
);

  psa_pkg::psa_cmd_t cmd;
  psa_pkg::psa_sts_t sts;

  // sequencer: owns the handshake on the command side
  psa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // slot table, bitmap memory and result register
  psa_dpath #(
    .SLOTS          (SLOTS),
    .PAGES_PER_SLOT (PAGES_PER_SLOT)
  ) u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .operation_i       (operation_i),
    .process_id_i      (process_id_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .status_o          (status_o),
    .slot_index_o      (slot_index_o),
    .virtual_address_o (virtual_address_o)
  );

endmodule

>>> hdl/psa_dpath.sv
// ----------------------------------------------------------------------------
// psa_dpath
// Slot owner table, page bitmap memory, first-free scan and result registers.
// ----------------------------------------------------------------------------
module psa_dpath #(
  parameter int SLOTS          = psa_pkg::SLOTS_DEF,
  parameter int PAGES_PER_SLOT = psa_pkg::PAGES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [psa_pkg::OP_W-1:0]      operation_i,
  input  logic [psa_pkg::ID_W-1:0]      process_id_i,
  input  psa_pkg::psa_cmd_t             cmd_i,
  output psa_pkg::psa_sts_t             sts_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [psa_pkg::STATUS_W-1:0]  status_o,
  output logic [psa_pkg::SLOT_IDX_W-1:0] slot_index_o,
  output logic [psa_pkg::VA_W-1:0]      virtual_address_o
);

  localparam int WORD_W = psa_pkg::WORD_W;
  localparam int BIT_W  = psa_pkg::BIT_W;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int WORDS  = (PAGES_PER_SLOT + WORD_W - 1) / WORD_W;
  localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ADDR_W = SLOT_W + WIDX_W;
  localparam int DEPTH  = 1 << ADDR_W;
  localparam int PIDX_W = WIDX_W + BIT_W;

  // command and slot table
  logic [psa_pkg::OP_W-1:0] op_q;
  logic [psa_pkg::ID_W-1:0] id_q;
  logic [psa_pkg::ID_W-1:0] owner_q [SLOTS];

  logic              hit, empty_avail;
  logic [SLOT_W-1:0] hit_slot, empty_slot, slot_q, slot_d;

  always_comb begin
    hit        = 1'b0;
    hit_slot   = '0;
    empty_avail = 1'b0;
    empty_slot = '0;
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (id_q != '0 && owner_q[s] == id_q) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(s);
      end
      if (owner_q[s] == '0) begin
        empty_avail = 1'b1;
        empty_slot  = SLOT_W'(s);
      end
    end
  end

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.set_slot) begin
      slot_d = (op_q == psa_pkg::OP_CREATE) ? empty_slot : hit_slot;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q <= operation_i;
      id_q <= process_id_i;
    end
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) begin
        owner_q[s] <= '0;
      end
    end else if (cmd_i.create_wr) begin
      owner_q[slot_d] <= id_q;
    end else if (cmd_i.owner_clr) begin
      owner_q[slot_d] <= '0;
    end
  end

  // bitmap word counter and clearing counter
  logic [WIDX_W-1:0] word_q;
  logic [ADDR_W-1:0] clr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
      clr_q  <= '0;
    end else begin
      if (cmd_i.word_clr) begin
        word_q <= '0;
      end else if (cmd_i.word_inc) begin
        word_q <= word_q + 1'b1;
      end
      if (cmd_i.mem_clr) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // page bitmap memory, one word per row
  logic [WORD_W-1:0] mem_q [DEPTH];
  logic [WORD_W-1:0] rd_q;
  logic [WORD_W-1:0] wdata, valid_mask, scan_word, bit_sel;
  logic [ADDR_W-1:0] addr;
  logic              wr_en;
  logic [BIT_W-1:0]  bit_idx;
  logic              page_free;

  assign addr  = cmd_i.mem_clr ? clr_q : {slot_q, word_q};
  assign wr_en = cmd_i.mem_clr | cmd_i.sweep_wr | cmd_i.mark_wr;
  assign wdata = cmd_i.mark_wr ? (rd_q | bit_sel) : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[addr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[addr];
    end
  end

  // bits past the last page read as used
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      valid_mask[b] = 32'({word_q, BIT_W'(b)}) < 32'(PAGES_PER_SLOT);
    end
  end

  assign scan_word = rd_q | ~valid_mask;
  assign page_free = ~&scan_word;

  always_comb begin
    bit_idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (!scan_word[b]) begin
        bit_idx = BIT_W'(b);
      end
    end
  end

  assign bit_sel = WORD_W'(1) << bit_idx;

  // result registers
  logic [PIDX_W-1:0]         page_idx;
  logic [psa_pkg::VA_W-1:0]  va;
  psa_pkg::status_e          res_status_q, out_status_q;
  logic [SLOT_W-1:0]         res_slot_q;
  logic [psa_pkg::VA_W-1:0]  res_va_q, out_va_q;
  logic [psa_pkg::SLOT_IDX_W-1:0] out_slot_q;
  logic                      out_valid_q;

  assign page_idx = {word_q, bit_idx};
  assign va = (psa_pkg::VA_W'(slot_q) << psa_pkg::VA_SLOT_SHIFT)
            | (psa_pkg::VA_W'(page_idx) << psa_pkg::VA_PAGE_SHIFT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_slot_q   <= cmd_i.res_use_slot ? slot_d : '0;
      res_va_q     <= cmd_i.res_va ? va : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_slot_q   <= psa_pkg::SLOT_IDX_W'(res_slot_q);
      out_va_q     <= res_va_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign slot_index_o      = out_slot_q;
  assign virtual_address_o = out_va_q;

  always_comb begin
    sts_o             = '0;
    sts_o.op          = op_q;
    sts_o.id_zero     = (id_q == '0);
    sts_o.hit         = hit;
    sts_o.empty_avail = empty_avail;
    sts_o.clr_last    = &clr_q;
    sts_o.word_last   = (word_q == WIDX_W'(WORDS - 1));
    sts_o.page_free   = page_free;
    sts_o.out_busy    = out_valid_q & ~out_ready_i;
  end

endmodule

>>> hdl/psa_ctrl.sv
// ----------------------------------------------------------------------------
// psa_ctrl
// Command sequencer: lookup, kill sweep, page scan and result hand-off.
// ----------------------------------------------------------------------------
module psa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  psa_pkg::psa_sts_t sts_i,
  output psa_pkg::psa_cmd_t cmd_o
);

  psa_pkg::psa_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psa_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      psa_pkg::S_CLEAR: begin
        if (sts_i.clr_last) state_d = psa_pkg::S_IDLE;
      end
      psa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = psa_pkg::S_LOOKUP;
      end
      psa_pkg::S_LOOKUP: begin
        state_d = psa_pkg::S_RESP;
        if (sts_i.hit && sts_i.op == psa_pkg::OP_KILL) state_d = psa_pkg::S_SWEEP;
        if (sts_i.hit && sts_i.op == psa_pkg::OP_ALLOC) state_d = psa_pkg::S_SCAN_RD;
      end
      psa_pkg::S_SWEEP: begin
        if (sts_i.word_last) state_d = psa_pkg::S_RESP;
      end
      psa_pkg::S_SCAN_RD: begin
        state_d = psa_pkg::S_SCAN_CHK;
      end
      psa_pkg::S_SCAN_CHK: begin
        if (sts_i.page_free || sts_i.word_last) begin
          state_d = psa_pkg::S_RESP;
        end else begin
          state_d = psa_pkg::S_SCAN_RD;
        end
      end
      psa_pkg::S_RESP: begin
        if (!sts_i.out_busy) state_d = psa_pkg::S_IDLE;
      end
      default: state_d = psa_pkg::S_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = psa_pkg::STS_NOT_FOUND;
    in_ready_o       = 1'b0;
    case (state_q)
      psa_pkg::S_CLEAR: begin
        cmd_o.mem_clr = 1'b1;
      end
      psa_pkg::S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      psa_pkg::S_LOOKUP: begin
        cmd_o.set_slot = 1'b1;
        cmd_o.res_set  = 1'b1;
        case (sts_i.op)
          psa_pkg::OP_CREATE: begin
            if (sts_i.id_zero) begin
              cmd_o.res_status = psa_pkg::STS_NOT_FOUND;
            end else if (sts_i.empty_avail) begin
              cmd_o.create_wr    = 1'b1;
              cmd_o.res_status   = psa_pkg::STS_OK;
              cmd_o.res_use_slot = 1'b1;
            end else begin
              cmd_o.res_status = psa_pkg::STS_NO_SLOT;
            end
          end
          psa_pkg::OP_KILL: begin
            if (sts_i.hit) begin
              cmd_o.owner_clr    = 1'b1;
              cmd_o.word_clr     = 1'b1;
              cmd_o.res_status   = psa_pkg::STS_OK;
              cmd_o.res_use_slot = 1'b1;
            end
          end
          psa_pkg::OP_ALLOC: begin
            if (sts_i.hit) begin
              cmd_o.word_clr = 1'b1;
              cmd_o.res_set  = 1'b0;
            end
          end
          default: cmd_o.res_status = psa_pkg::STS_NOT_FOUND;
        endcase
      end
      psa_pkg::S_SWEEP: begin
        cmd_o.sweep_wr = 1'b1;
        cmd_o.word_inc = 1'b1;
      end
      psa_pkg::S_SCAN_RD: begin
        cmd_o.mem_rd = 1'b1;
      end
      psa_pkg::S_SCAN_CHK: begin
        if (sts_i.page_free) begin
          cmd_o.mark_wr      = 1'b1;
          cmd_o.res_set      = 1'b1;
          cmd_o.res_status   = psa_pkg::STS_OK;
          cmd_o.res_use_slot = 1'b1;
          cmd_o.res_va       = 1'b1;
        end else if (sts_i.word_last) begin
          cmd_o.res_set      = 1'b1;
          cmd_o.res_status   = psa_pkg::STS_NO_PAGE;
          cmd_o.res_use_slot = 1'b1;
        end else begin
          cmd_o.word_inc = 1'b1;
        end
      end
      psa_pkg::S_RESP: begin
        cmd_o.out_load = ~sts_i.out_busy;
      end
      default: cmd_o = '0;
    endcase
  end

`ifndef NO_ASSERTIONS
  // result never overwrites one still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !sts_i.out_busy)
    else $error("output overwritten while stalled");

  // a page is only marked when the scanned word has a free bit
  a_mark_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mark_wr |-> (sts_i.page_free && state_q == psa_pkg::S_SCAN_CHK))
    else $error("page marked without a free bit");

  // kill sweep ends after the last word of the slot
  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == psa_pkg::S_SWEEP && sts_i.word_last) |=> state_q == psa_pkg::S_RESP)
    else $error("kill sweep overran");

  // an accepted command is looked up on the next cycle
  a_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> state_q == psa_pkg::S_LOOKUP)
    else $error("command not looked up");
`endif

endmodule

>>> test/process_page_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// process_page_slot_allocator_tb
// Self-checking bench for the process slot table and its per-slot page bitmap.
// Commands go in on the valid/ready command channel with random gaps. Results
// are taken on the result channel under random back-pressure. Each result is
// compared against a software copy of the slot table and the page bitmaps.
// ----------------------------------------------------------------------------
module process_page_slot_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycle budget.
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int RANDOM_CMDS  = 470;
  localparam int SETTLE_CYCLES = 80;
  localparam int MAX_SHOWN    = 10;

  // Operation code the block does not define; it must answer "not found".
  localparam logic [psa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

  localparam logic [psa_pkg::ID_W-1:0] ID_ALL_ONES = {psa_pkg::ID_W{1'b1}};
  localparam logic [psa_pkg::ID_W-1:0] ID_ONE      = 64'd1;
  localparam logic [psa_pkg::ID_W-1:0] ID_TOP_BIT  = 64'h8000_0000_0000_0000;
  localparam logic [psa_pkg::ID_W-1:0] ID_ALT      = 64'h5555_5555_5555_5555;
  localparam logic [psa_pkg::ID_W-1:0] ID_ABSENT   = 64'd5;

  typedef struct {
    psa_pkg::status_e                 status;
    logic [psa_pkg::SLOT_IDX_W-1:0]   slot;
    logic [psa_pkg::VA_W-1:0]         vaddr;
  } alloc_result_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the slot owners and page bitmaps, plus the queue of
  // results still owed by the block.
  // --------------------------------------------------------------------------
  class page_alloc_scoreboard;
    logic [psa_pkg::ID_W-1:0] owner [psa_pkg::SLOTS_DEF];
    bit              page_taken [psa_pkg::SLOTS_DEF][psa_pkg::PAGES_DEF];
    alloc_result_t   owed [$];
    int              errors;

    function new();
      foreach (owner[s]) owner[s] = '0;
      foreach (page_taken[s, p]) page_taken[s][p] = 1'b0;
      errors = 0;
    endfunction

    // Lowest slot owned by id; SLOTS_DEF when none. Zero never matches.
    function int find_owner(logic [psa_pkg::ID_W-1:0] id);
      if (id == '0) return psa_pkg::SLOTS_DEF;
      for (int s = 0; s < psa_pkg::SLOTS_DEF; s++)
        if (owner[s] == id) return s;
      return psa_pkg::SLOTS_DEF;
    endfunction

    function void note_command(logic [psa_pkg::OP_W-1:0] op,
                               logic [psa_pkg::ID_W-1:0] id);
      alloc_result_t r;
      int            s;
      r.status = psa_pkg::STS_NOT_FOUND;
      r.slot   = '0;
      r.vaddr  = '0;
      case (op)
        psa_pkg::OP_CREATE: begin
          if (id != '0) begin
            r.status = psa_pkg::STS_NO_SLOT;
            for (s = 0; s < psa_pkg::SLOTS_DEF; s++) begin
              if (owner[s] == '0) begin
                owner[s] = id;
                r.status = psa_pkg::STS_OK;
                r.slot   = psa_pkg::SLOT_IDX_W'(s);
                break;
              end
            end
          end
        end
        psa_pkg::OP_KILL: begin
          s = find_owner(id);
          if (s < psa_pkg::SLOTS_DEF) begin
            owner[s] = '0;
            for (int p = 0; p < psa_pkg::PAGES_DEF; p++) page_taken[s][p] = 1'b0;
            r.status = psa_pkg::STS_OK;
            r.slot   = psa_pkg::SLOT_IDX_W'(s);
          end
        end
        psa_pkg::OP_ALLOC: begin
          s = find_owner(id);
          if (s < psa_pkg::SLOTS_DEF) begin
            r.status = psa_pkg::STS_NO_PAGE;
            r.slot   = psa_pkg::SLOT_IDX_W'(s);
            for (int p = 0; p < psa_pkg::PAGES_DEF; p++) begin
              if (!page_taken[s][p]) begin
                page_taken[s][p] = 1'b1;
                r.status = psa_pkg::STS_OK;
                r.vaddr  = psa_pkg::VA_W'((s << psa_pkg::VA_SLOT_SHIFT)
                                          | (p << psa_pkg::VA_PAGE_SHIFT));
                break;
              end
            end
          end
        end
        default: ;
      endcase
      owed.push_back(r);
    endfunction

    function void check_result(logic [psa_pkg::STATUS_W-1:0] status,
                               logic [psa_pkg::SLOT_IDX_W-1:0] slot,
                               logic [psa_pkg::VA_W-1:0] vaddr);
      alloc_result_t e;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("unexpected result: status %0d slot %0d va %06h", status, slot, vaddr);
        return;
      end
      e = owed.pop_front();
      if (status !== e.status || slot !== e.slot || vaddr !== e.vaddr) begin
        errors++;
        if (errors <= MAX_SHOWN)
          $display("mismatch: expected status %0d slot %0d va %06h, got %0d %0d %06h",
                   e.status, e.slot, e.vaddr, status, slot, vaddr);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT hookup. All inputs start at known values.
  // --------------------------------------------------------------------------
  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           in_valid_i   = 1'b0;
  logic                           in_ready_o;
  logic [psa_pkg::OP_W-1:0]       operation_i  = '0;
  logic [psa_pkg::ID_W-1:0]       process_id_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i  = 1'b0;
  logic [psa_pkg::STATUS_W-1:0]   status_o;
  logic [psa_pkg::SLOT_IDX_W-1:0] slot_index_o;
  logic [psa_pkg::VA_W-1:0]       virtual_address_o;

  page_alloc_scoreboard     board;
  int                       send_quiet = 0;
  int                       recv_quiet = 0;
  int                       cycles     = 0;
  logic [psa_pkg::ID_W-1:0] id_pool [6];

  process_page_slot_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .operation_i      (operation_i),
    .process_id_i     (process_id_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .slot_index_o     (slot_index_o),
    .virtual_address_o(virtual_address_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: any hang ends the run as a failure.
  initial begin
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Random gap before each transfer, with occasional stretches of no gaps.
  function automatic int pick_gap(inout int quiet);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) quiet = $urandom_range(10, 40);
    return $urandom_range(0, 7);
  endfunction

  function automatic logic [psa_pkg::ID_W-1:0] random_id();
    return {$urandom, $urandom};
  endfunction

  // One command transfer. Valid only drops when a gap is drawn, so
  // back-to-back commands keep it high across the edge.
  task automatic send_command(input logic [psa_pkg::OP_W-1:0] op,
                              input logic [psa_pkg::ID_W-1:0] id);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    operation_i  <= op;
    process_id_i <= id;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_command(op, id);
  endtask

  // Hold off the command side until every owed result has come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (board.owed.size() != 0);
  endtask

  // Result side: random ready stalls, check on every transfer.
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = pick_gap(recv_quiet);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      board.check_result(status_o, slot_index_o, virtual_address_o);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int pick;
    board = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero id on every op, undefined op, duplicate create,
    // full table, lowest-slot lookup after a duplicate, kill frees pages.
    send_command(psa_pkg::OP_CREATE, '0);
    send_command(psa_pkg::OP_KILL,   '0);
    send_command(psa_pkg::OP_ALLOC,  '0);
    send_command(OP_UNUSED, ID_ALL_ONES);
    send_command(psa_pkg::OP_ALLOC,  ID_ALL_ONES);      // not created yet
    send_command(psa_pkg::OP_CREATE, ID_ALL_ONES);      // slot 0
    send_command(psa_pkg::OP_CREATE, ID_ONE);           // slot 1
    send_command(psa_pkg::OP_CREATE, ID_ONE);           // duplicate -> slot 2
    send_command(psa_pkg::OP_CREATE, ID_TOP_BIT);       // slot 3
    send_command(psa_pkg::OP_CREATE, ID_ABSENT);        // table full
    send_command(psa_pkg::OP_ALLOC,  ID_ALL_ONES);
    send_command(psa_pkg::OP_ALLOC,  ID_ALL_ONES);
    send_command(psa_pkg::OP_ALLOC,  ID_ONE);           // lowest matching slot
    send_command(psa_pkg::OP_ALLOC,  ID_TOP_BIT);
    send_command(psa_pkg::OP_KILL,   ID_ONE);           // kills slot 1 only
    send_command(psa_pkg::OP_ALLOC,  ID_ONE);           // now found in slot 2
    send_command(psa_pkg::OP_KILL,   ID_ABSENT);
    send_command(OP_UNUSED, '0);
    send_command(psa_pkg::OP_CREATE, ID_ALT);           // refills slot 1
    send_command(psa_pkg::OP_KILL,   ID_ALL_ONES);
    send_command(psa_pkg::OP_CREATE, ID_ALL_ONES);      // back into slot 0
    send_command(psa_pkg::OP_ALLOC,  ID_ALL_ONES);      // page 0 again after the kill
    send_command(psa_pkg::OP_CREATE, '0);

    drain_results();

    // Kill slot 3, miss on it, then recreate it and take page 0 again.
    send_command(psa_pkg::OP_KILL,   ID_TOP_BIT);
    send_command(psa_pkg::OP_ALLOC,  ID_TOP_BIT);
    send_command(psa_pkg::OP_CREATE, ID_TOP_BIT);
    send_command(psa_pkg::OP_ALLOC,  ID_TOP_BIT);

    // Random phase: commands mostly name ids from a small pool so lookups
    // hit; the rest is noise (random ids, zero id, undefined op).
    id_pool[0] = ID_ALL_ONES;
    id_pool[1] = ID_ONE;
    id_pool[2] = ID_TOP_BIT;
    for (int i = 3; i < 6; i++) begin
      do id_pool[i] = random_id(); while (id_pool[i] == '0);
    end

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 18)
        send_command(psa_pkg::OP_CREATE, id_pool[$urandom_range(0, 5)]);
      else if (pick < 30)
        send_command(psa_pkg::OP_KILL, id_pool[$urandom_range(0, 5)]);
      else if (pick < 88)
        send_command(psa_pkg::OP_ALLOC, id_pool[$urandom_range(0, 5)]);
      else if (pick < 92)
        // Noise commands with a random id: kill or allocate, chosen by parity.
        send_command((pick % 2 == 0) ? psa_pkg::OP_ALLOC : psa_pkg::OP_KILL,
                     random_id());
      else if (pick < 96)
        send_command(psa_pkg::OP_W'($urandom_range(0, 3)), '0);
      else
        send_command(OP_UNUSED, random_id());
      if ($urandom_range(0, 49) == 0) drain_results();
    end

    // Wind down: everything owed must arrive, then a quiet tail for strays.
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> process_page_slot_allocator.f
hdl/psa_pkg.sv
hdl/psa_dpath.sv
hdl/psa_ctrl.sv
hdl/process_page_slot_allocator.sv
test/process_page_slot_allocator_tb.sv
